### rtl/psnf_pkg.sv
// Shared types, widths and tables for the plane normal fit block.
package psnf_pkg;

  localparam int DEF_MAX_POINTS = 1024;
  localparam int DEF_COORD_BITS = 16;

  localparam int SUM_W  = 48;             // moment sums
  localparam int HALF_W = SUM_W / 2;      // partial product operand split
  localparam int PP_W   = 2 * (HALF_W + 1);
  localparam int ACC_W  = 2 * SUM_W + 2;  // a*b - c*d, exact
  localparam int MAG_W  = ACC_W - 1;
  localparam int SH_W   = 30;             // placed magnitude, top bit at 29
  localparam int SQ_W   = 2 * SH_W;
  localparam int RV_W   = 63;             // square root radicand
  localparam int N_W    = 32;             // square root result
  localparam int DV_W   = N_W + 1;        // divisor 2n
  localparam int NUM_W  = SH_W + 17;      // (sh << 16) + n
  localparam int Q_W    = 17;
  localparam int REM_W  = DV_W + 1;
  localparam int OUT_W  = 16;
  localparam int QDEPTH = 4;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [Q_W-1:0]   SAT_POS_Q = Q_W'(32767);
  localparam logic [Q_W-1:0]   SAT_NEG_Q = Q_W'(32768);
  localparam logic [OUT_W-1:0] SAT_POS   = 16'h7fff;
  localparam logic [OUT_W-1:0] SAT_NEG   = 16'h8000;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DEGEN = 2'd1,
    ST_OVF   = 2'd2
  } fit_status_t;

  typedef enum logic [2:0] {M_XX, M_YY, M_ZZ, M_XY, M_XZ, M_YZ} mom_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] xx;
    logic signed [SUM_W-1:0] yy;
    logic signed [SUM_W-1:0] zz;
    logic signed [SUM_W-1:0] xy;
    logic signed [SUM_W-1:0] xz;
    logic signed [SUM_W-1:0] yz;
    logic                    ovf;
  } snap_t;

  typedef struct packed {
    mom_t a;
    mom_t b;
    mom_t c;
    mom_t d;
  } cross_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CROSS, S_PICK, S_ASM, S_MAX, S_SCAN, S_PLACE,
    S_SQ, S_SQRT, S_DIVI, S_DIV, S_RES
  } solve_state_t;

  // Operands of a*b - c*d: jobs 0..2 are the minors, 3..4 the numerators
  function automatic cross_t cross_job(logic [2:0] job, logic [1:0] idx);
    cross_t j;
    j = '{M_YY, M_ZZ, M_YZ, M_YZ};
    case (job)
      3'd0: j = '{M_YY, M_ZZ, M_YZ, M_YZ};
      3'd1: j = '{M_XX, M_ZZ, M_XZ, M_XZ};
      3'd2: j = '{M_XX, M_YY, M_XY, M_XY};
      3'd3: begin
        case (idx)
          2'd0:    j = '{M_YZ, M_XZ, M_XY, M_ZZ};
          2'd1:    j = '{M_XZ, M_YZ, M_XY, M_ZZ};
          default: j = '{M_YZ, M_XY, M_XZ, M_YY};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    j = '{M_YZ, M_XY, M_XZ, M_YY};
          2'd1:    j = '{M_XZ, M_XY, M_YZ, M_XX};
          default: j = '{M_XY, M_XZ, M_XX, M_YZ};
        endcase
      end
    endcase
    return j;
  endfunction

endpackage

### rtl/psnf_if.sv
// Point and result channel interfaces.
interface psnf_pt_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic                         last_point;

  modport source(output valid, coord_x, coord_y, coord_z, last_point, input ready);
  modport sink(input valid, coord_x, coord_y, coord_z, last_point, output ready);
endinterface

interface psnf_fit_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic [1:0]         fit_status;

  modport source(output valid, normal_x, normal_y, normal_z, fit_status, input ready);
  modport sink(input valid, normal_x, normal_y, normal_z, fit_status, output ready);
endinterface

### rtl/psnf_front.sv
// Front part: takes points, multiplies and accumulates the six moments.
module psnf_front import psnf_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic              clk,
  input  logic              rst,
  psnf_pt_if.sink           pt,
  input  logic [QCNT_W-1:0] q_cnt,
  output logic              push,
  output snap_t             push_data
);

  localparam int CNT_W = $clog2(MAX_POINTS + 2);
  localparam int P_W   = 2 * COORD_BITS;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

  logic [CNT_W-1:0] cnt;
  logic s1_vld, s1_last, s1_acc;
  logic signed [COORD_BITS-1:0] s1_x, s1_y, s1_z;
  logic s2_vld, s2_last, s2_acc;
  logic signed [P_W-1:0] s2_p [6];
  logic signed [SUM_W-1:0] sums [6];
  logic signed [SUM_W-1:0] sums_next [6];
  logic take;
  logic [QCNT_W:0] held;

  // count results that may still land in the queue
  assign held = {1'b0, q_cnt} + (QCNT_W+1)'(s1_vld & s1_last) + (QCNT_W+1)'(s2_vld & s2_last);
  assign pt.ready = held < (QCNT_W+1)'(QDEPTH);
  assign take = pt.valid & pt.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      for (int k = 0; k < 6; k++) sums[k] <= '0;
    end else begin
      s1_vld <= take;
      if (take) begin
        s1_acc <= cnt < CNT_MAX;
        s1_last <= pt.last_point;
        if (pt.last_point) cnt <= '0;
        else if (cnt < CNT_MAX) cnt <= cnt + CNT_W'(1);
        else cnt <= CNT_MAX + CNT_W'(1);
      end
      s2_vld <= s1_vld;
      if (s2_vld) begin
        for (int k = 0; k < 6; k++) sums[k] <= s2_last ? '0 : sums_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_x <= pt.coord_x;
      s1_y <= pt.coord_y;
      s1_z <= pt.coord_z;
    end
    s2_last <= s1_last;
    s2_acc <= s1_acc;
    s2_p[0] <= s1_x * s1_x;
    s2_p[1] <= s1_y * s1_y;
    s2_p[2] <= s1_z * s1_z;
    s2_p[3] <= s1_x * s1_y;
    s2_p[4] <= s1_x * s1_z;
    s2_p[5] <= s1_y * s1_z;
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      sums_next[k] = sums[k] +
        (s2_acc ? {{(SUM_W-P_W){s2_p[k][P_W-1]}}, s2_p[k]} : SUM_W'(0));
    end
  end

  assign push = s2_vld & s2_last;
  assign push_data = '{xx: sums_next[0], yy: sums_next[1], zz: sums_next[2],
                       xy: sums_next[3], xz: sums_next[4], yz: sums_next[5],
                       ovf: ~s2_acc};

endmodule

### rtl/psnf_queue.sv
// Short queue of closed moment sets between front and back.
module psnf_queue import psnf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  snap_t             push_data,
  input  logic              pop,
  output snap_t             head,
  output logic [QCNT_W-1:0] cnt
);

  localparam int PTR_W = $clog2(QDEPTH);

  snap_t            ent [QDEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      cnt <= cnt + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent[wr_ptr] <= push_data;
  end

  assign head = ent[rd_ptr];

endmodule

### rtl/psnf_solve.sv
// Back part: sequenced minors, normalization, square root and divides.
module psnf_solve import psnf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  snap_t             head,
  input  logic [QCNT_W-1:0] q_cnt,
  output logic              pop,
  psnf_fit_if.source        fit
);

  solve_state_t st, st_next;

  snap_t                    sn;
  logic [2:0]               job;
  logic [3:0]               step;
  logic signed [PP_W-1:0]   prod;
  logic                     psub;
  logic [1:0]               pshf;
  logic signed [ACC_W-1:0]  acc;
  logic [MAG_W-1:0]         dmag [3];
  logic                     dneg [3];
  logic [MAG_W-1:0]         nmag [2];
  logic                     nneg [2];
  logic [1:0]               idx;
  logic [MAG_W-1:0]         vmag [3];
  logic                     vneg [3];
  logic [MAG_W-1:0]         vmax;
  logic [6:0]               pos;
  logic [6:0]               len;
  logic [SH_W-1:0]          sh [3];
  logic [1:0]               cnt;
  logic [SQ_W-1:0]          sq;
  logic [RV_W-1:0]          rv, res;
  logic [4:0]               kbit;
  logic [NUM_W-1:0]         num;
  logic [REM_W-1:0]         rem;
  logic [Q_W-1:0]           quo;
  logic [4:0]               dbit;
  logic [OUT_W-1:0]         onorm [3];
  fit_status_t              ost;
  logic                     ovld;

  // combinational helpers
  cross_t                   cj;
  logic signed [SUM_W-1:0]  op1, op2;
  logic signed [HALF_W:0]   h1, h2;
  logic signed [ACC_W-1:0]  pe, pes, acc_neg;
  logic [MAG_W-1:0]         acc_mag;
  logic [MAG_W-1:0]         pk_best;
  logic [1:0]               pk_idx;
  logic [MAG_W-1:0]         mx01;
  logic [SH_W-1:0]          placed;
  logic [MAG_W-1:0]         shifted;
  logic [6:0]               sh_amt;
  logic [RV_W-1:0]          bitv, trial;
  logic [N_W-1:0]           nroot;
  logic [DV_W-1:0]          dvsr;
  logic [NUM_W-1:0]         num_c;
  logic [REM_W-1:0]         rem2;

  function automatic logic signed [SUM_W-1:0] mval(snap_t s, mom_t m);
    logic signed [SUM_W-1:0] v;
    v = s.xx;
    unique case (m)
      M_XX:    v = s.xx;
      M_YY:    v = s.yy;
      M_ZZ:    v = s.zz;
      M_XY:    v = s.xy;
      M_XZ:    v = s.xz;
      M_YZ:    v = s.yz;
      default: v = s.xx;
    endcase
    return v;
  endfunction

  function automatic logic signed [HALF_W:0] half(logic signed [SUM_W-1:0] v, logic hi);
    return hi ? {v[SUM_W-1], v[SUM_W-1:HALF_W]} : {1'b0, v[HALF_W-1:0]};
  endfunction

  always_comb begin
    cj = cross_job(job, idx);
    op1 = step[2] ? mval(sn, cj.c) : mval(sn, cj.a);
    op2 = step[2] ? mval(sn, cj.d) : mval(sn, cj.b);
    h1 = half(op1, ~step[1]);
    h2 = half(op2, ~step[0]);

    pe = {{(ACC_W-PP_W){prod[PP_W-1]}}, prod};
    case (pshf)
      2'd0:    pes = pe;
      2'd1:    pes = pe <<< HALF_W;
      default: pes = pe <<< (2 * HALF_W);
    endcase
    acc_neg = -acc;
    acc_mag = acc[ACC_W-1] ? acc_neg[MAG_W-1:0] : acc[MAG_W-1:0];

    // largest minor, first one wins a tie
    pk_best = dmag[0];
    pk_idx = 2'd0;
    if (dmag[1] > pk_best) begin
      pk_best = dmag[1];
      pk_idx = 2'd1;
    end
    if (dmag[2] > pk_best) begin
      pk_best = dmag[2];
      pk_idx = 2'd2;
    end

    mx01 = (vmag[1] > vmag[0]) ? vmag[1] : vmag[0];

    // put the top bit of the largest magnitude at bit 29
    if (len <= 7'(SH_W)) begin
      sh_amt = 7'(SH_W) - len;
      shifted = '0;
      placed = vmag[cnt][SH_W-1:0] << sh_amt[4:0];
    end else begin
      sh_amt = len - 7'(SH_W);
      shifted = vmag[cnt] >> sh_amt;
      placed = shifted[SH_W-1:0];
    end

    bitv = RV_W'(1) << {kbit, 1'b0};
    trial = res + bitv;
    nroot = res[N_W-1:0];
    dvsr = {nroot, 1'b0};
    num_c = NUM_W'({sh[cnt], 16'b0}) + NUM_W'(nroot);
    rem2 = {rem[REM_W-2:0], num[{1'b0, dbit}]};
  end

  always_comb begin
    st_next = st;
    pop = 1'b0;
    unique case (st)
      S_IDLE: begin
        if (q_cnt != '0 && !ovld) begin
          pop = 1'b1;
          st_next = head.ovf ? S_IDLE : S_CROSS;
        end
      end
      S_CROSS: begin
        if (step == 4'd9) begin
          if (job == 3'd2) st_next = S_PICK;
          else if (job == 3'd4) st_next = S_ASM;
        end
      end
      S_PICK:  st_next = (pk_best == '0) ? S_IDLE : S_CROSS;
      S_ASM:   st_next = S_MAX;
      S_MAX:   st_next = S_SCAN;
      S_SCAN:  if (vmax[pos]) st_next = S_PLACE;
      S_PLACE: if (cnt == 2'd2) st_next = S_SQ;
      S_SQ:    if (cnt == 2'd3) st_next = S_SQRT;
      S_SQRT:  if (kbit == 5'd0) st_next = S_DIVI;
      S_DIVI:  st_next = S_DIV;
      S_DIV:   if (dbit == 5'd0) st_next = S_RES;
      S_RES:   st_next = (cnt == 2'd2) ? S_IDLE : S_DIVI;
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      ovld <= 1'b0;
    end else begin
      st <= st_next;
      if (fit.valid && fit.ready) ovld <= 1'b0;
      if ((st == S_IDLE && pop && head.ovf) || (st == S_PICK && pk_best == '0) ||
          (st == S_RES && cnt == 2'd2)) ovld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st)
      S_IDLE: begin
        sn <= head;
        job <= '0;
        step <= '0;
        acc <= '0;
        if (pop && head.ovf) begin
          for (int k = 0; k < 3; k++) onorm[k] <= '0;
          ost <= ST_OVF;
        end
      end
      S_CROSS: begin
        // issue one partial product, add the previous one
        prod <= h1 * h2;
        psub <= step[2];
        pshf <= 2'(!step[1]) + 2'(!step[0]);
        if (step != 4'd0 && step != 4'd9) acc <= psub ? acc - pes : acc + pes;
        if (step == 4'd9) begin
          if (job == 3'd3) begin
            nmag[0] <= acc_mag;
            nneg[0] <= acc[ACC_W-1];
          end else if (job == 3'd4) begin
            nmag[1] <= acc_mag;
            nneg[1] <= acc[ACC_W-1];
          end else begin
            dmag[job[1:0]] <= acc_mag;
            dneg[job[1:0]] <= acc[ACC_W-1];
          end
          acc <= '0;
          step <= '0;
          if (job != 3'd2) job <= job + 3'd1;
        end else begin
          step <= step + 4'd1;
        end
      end
      S_PICK: begin
        idx <= pk_idx;
        job <= 3'd3;
        if (pk_best == '0) begin
          for (int k = 0; k < 3; k++) onorm[k] <= '0;
          ost <= ST_DEGEN;
        end
      end
      S_ASM: begin
        case (idx)
          2'd0: begin
            vmag[0] <= dmag[0];
            vmag[1] <= nmag[0];
            vmag[2] <= nmag[1];
            vneg[0] <= 1'b0;
            vneg[1] <= (nmag[0] != '0) && (nneg[0] ^ dneg[0]);
            vneg[2] <= (nmag[1] != '0) && (nneg[1] ^ dneg[0]);
          end
          2'd1: begin
            vmag[0] <= nmag[0];
            vmag[1] <= dmag[1];
            vmag[2] <= nmag[1];
            vneg[0] <= (nmag[0] != '0) && (nneg[0] ^ dneg[1]);
            vneg[1] <= 1'b0;
            vneg[2] <= (nmag[1] != '0) && (nneg[1] ^ dneg[1]);
          end
          default: begin
            vmag[0] <= nmag[0];
            vmag[1] <= nmag[1];
            vmag[2] <= dmag[2];
            vneg[0] <= (nmag[0] != '0) && (nneg[0] ^ dneg[2]);
            vneg[1] <= (nmag[1] != '0) && (nneg[1] ^ dneg[2]);
            vneg[2] <= 1'b0;
          end
        endcase
      end
      S_MAX: begin
        vmax <= (vmag[2] > mx01) ? vmag[2] : mx01;
        pos <= 7'(MAG_W - 1);
        cnt <= '0;
      end
      S_SCAN: begin
        if (vmax[pos]) len <= pos + 7'd1;
        else pos <= pos - 7'd1;
      end
      S_PLACE: begin
        sh[cnt] <= placed;
        rv <= '0;
        cnt <= (cnt == 2'd2) ? 2'd0 : cnt + 2'd1;
      end
      S_SQ: begin
        if (cnt != 2'd3) sq <= sh[cnt] * sh[cnt];
        if (cnt != 2'd0) rv <= rv + RV_W'(sq);
        cnt <= cnt + 2'd1;
        res <= '0;
        kbit <= 5'd31;
      end
      S_SQRT: begin
        if (rv >= trial) begin
          rv <= rv - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        kbit <= kbit - 5'd1;
        cnt <= '0;
      end
      S_DIVI: begin
        num <= num_c;
        rem <= REM_W'(num_c[NUM_W-1:Q_W]);
        dbit <= 5'(Q_W - 1);
      end
      S_DIV: begin
        if (rem2 >= REM_W'(dvsr)) begin
          rem <= rem2 - REM_W'(dvsr);
          quo[dbit] <= 1'b1;
        end else begin
          rem <= rem2;
          quo[dbit] <= 1'b0;
        end
        dbit <= dbit - 5'd1;
      end
      S_RES: begin
        if (vneg[cnt]) onorm[cnt] <= (quo > SAT_NEG_Q) ? SAT_NEG : OUT_W'(-quo);
        else onorm[cnt] <= (quo > SAT_POS_Q) ? SAT_POS : quo[OUT_W-1:0];
        ost <= ST_OK;
        cnt <= cnt + 2'd1;
      end
      default: ;
    endcase
  end

  assign fit.valid = ovld;
  assign fit.normal_x = onorm[0];
  assign fit.normal_y = onorm[1];
  assign fit.normal_z = onorm[2];
  assign fit.fit_status = ost;

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    st == S_DIV |-> dvsr != '0) else $error("divide by zero root");
  a_pop_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> !ovld && q_cnt != '0) else $error("set taken while result pending");
  a_quo_range: assert property (@(posedge clk) disable iff (rst)
    st == S_RES |-> quo <= SAT_NEG_Q) else $error("quotient out of range");

endmodule

### rtl/point_set_plane_normal_fit.sv
// Plane-through-origin normal fit over streamed point sets.
// Channel pt carries one 3-D point per item (coord_x/y/z, last_point);
// channel fit carries one unit normal in Q1.15 with fit_status per set.
// Both are valid/ready; an item moves when valid and ready are high at
// a rising edge of clk.
// Points are taken one per cycle, while pt.ready is high, into a
// multiply-accumulate pipeline. The point that carries last_point closes
// the set: its moments go into a four-entry queue and the solver picks
// them up from there. The solver runs three exact cross products for the
// minors and, unless all are zero, two for the numerators, all on one shared
// 25x25 multiplier; then a bit scan to place the largest magnitude, a 32-step
// square root and three restoring divides. Overflowed sets skip all of these.
// pt.ready drops only while the queue plus sets in flight would fill it.
// The result stays in the output register until fit.ready takes it; the
// solver does not start the next set until then.
// rst (synchronous, active high) clears the sums, the count, the queue and
// drops any pending result.
module point_set_plane_normal_fit import psnf_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input logic        clk,
  input logic        rst,
  psnf_pt_if.sink    pt,
  psnf_fit_if.source fit
);

  logic              push, pop;
  snap_t             push_data, head;
  logic [QCNT_W-1:0] q_cnt;

  psnf_front #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst, .pt, .q_cnt, .push, .push_data
  );

  psnf_queue u_queue (
    .clk, .rst, .push, .push_data, .pop, .head, .cnt(q_cnt)
  );

  psnf_solve u_solve (
    .clk, .rst, .head, .q_cnt, .pop, .fit
  );

endmodule
